// File: src/hkvs_pkg.sv
// Shared constants, codes and types of the hashed key/value store.
package hkvs_pkg;

    // Node store size and stored value width.
    localparam int MAX_KEYS   = 256;
    localparam int VALUE_BITS = 32;

    // Node index: one code above the last entry stands for "no node".
    localparam int ADDR_W = $clog2(MAX_KEYS);
    localparam int IDX_W  = $clog2(MAX_KEYS + 1);
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_KEYS);

    // Fixed field widths of the item channels.
    localparam int HASH_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int VAL_PORT_W   = 32;
    localparam int STATUS_W     = 3;
    localparam int COUNT_PORT_W = 9;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 80;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd4;

    // One tree node as held in the node store.
    typedef struct packed {
        logic [HASH_W-1:0]     hash;
        logic [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]      left;
        logic [IDX_W-1:0]      right;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    // Controller to datapath commands.
    typedef struct packed {
        logic hash_byte;   // fold the accepted key byte
        logic mix_start;   // final mix, start walk at root
        logic walk;        // one tree level per cycle
        logic write_link;  // hook new node into its parent
        logic write_node;  // write new node, bump count
        logic load_out;    // load the result register
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic walk_done;
        logic do_insert;
        logic par_null;
        logic out_free;
    } t_dp_sts;

endpackage

// File: src/hkvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hkvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/hkvs_dp.sv
// Datapath: hash registers, tree walk, node store access and result register.
module hkvs_dp import hkvs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic                    i_command,
    input  logic [BYTE_W-1:0]       i_key_byte,
    input  logic                    i_key_last,
    input  logic [VAL_PORT_W-1:0]   i_value,
    input  logic                    i_m_tready,
    output logic                    o_out_valid,
    output logic [STATUS_W-1:0]     o_status,
    output logic [VAL_PORT_W-1:0]   o_found_value,
    output logic [HASH_W-1:0]       o_key_hash,
    output logic [COUNT_PORT_W-1:0] o_key_count
);

    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] t;
        t = h + HASH_W'(b);
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [HASH_W-1:0] final_mix(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

    // control state
    logic [HASH_W-1:0]     r_hash;
    logic [IDX_W-1:0]      r_root;
    logic [IDX_W-1:0]      r_count;
    logic                  r_out_valid;
    // payload
    logic                  r_cmd;
    logic [VALUE_BITS-1:0] r_value;
    logic [HASH_W-1:0]     r_key_hash;
    logic [IDX_W-1:0]      r_cur;
    logic [IDX_W-1:0]      r_parent;
    logic                  r_go_left;
    t_node                 r_par_node;
    logic [STATUS_W-1:0]   r_status;
    logic [VALUE_BITS-1:0] r_found;
    logic [STATUS_W-1:0]   r_out_status;
    logic [VALUE_BITS-1:0] r_out_found;
    logic [HASH_W-1:0]     r_out_hash;
    logic [IDX_W-1:0]      r_out_count;

    t_node               ram_rdata;
    t_node               ram_wdata;
    t_node               link_node;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]    n_cur;
    logic [STATUS_W-1:0] n_status;
    logic                cur_null;
    logic                hit;
    logic                go_left;
    logic                full;

    assign cur_null = (r_cur >= NULL_IDX);
    assign hit      = !cur_null && (ram_rdata.hash == r_key_hash);
    assign go_left  = (r_key_hash < ram_rdata.hash);
    assign full     = (r_count >= NULL_IDX);

    assign o_sts.walk_done = cur_null || hit;
    assign o_sts.do_insert = !r_cmd && !hit && !full;
    assign o_sts.par_null  = (r_parent >= NULL_IDX);
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    // next node to visit; the read is issued from it so data is ready next cycle
    always_comb begin
        n_cur = r_cur;
        if (i_cmd.mix_start) begin
            n_cur = r_root;
        end else if (i_cmd.walk && !o_sts.walk_done) begin
            n_cur = go_left ? ram_rdata.left : ram_rdata.right;
        end
    end

    always_comb begin
        if (r_cmd) begin
            n_status = hit ? ST_HIT : ST_MISS;
        end else if (hit) begin
            n_status = ST_DUPLICATE;
        end else if (full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_INSERTED;
        end
    end

    always_comb begin
        link_node = r_par_node;
        if (r_go_left) begin
            link_node.left = r_count;
        end else begin
            link_node.right = r_count;
        end
    end

    always_comb begin
        ram_we    = i_cmd.write_link || i_cmd.write_node;
        ram_waddr = r_count[ADDR_W-1:0];
        ram_wdata = '{hash: r_key_hash, value: r_value, left: NULL_IDX, right: NULL_IDX};
        if (i_cmd.write_link) begin
            ram_waddr = r_parent[ADDR_W-1:0];
            ram_wdata = link_node;
        end
    end

    hkvs_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_KEYS)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_cur[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_root      <= NULL_IDX;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.hash_byte) begin
                r_hash <= fold_byte(r_hash, i_key_byte);
            end else if (i_cmd.mix_start) begin
                r_hash <= '0;
            end
            if (i_cmd.write_node) begin
                r_count <= r_count + 1'b1;
                if (o_sts.par_null) begin
                    r_root <= r_count;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_byte && i_key_last) begin
            r_cmd   <= i_command;
            r_value <= VALUE_BITS'(i_value);
        end
        if (i_cmd.mix_start) begin
            r_key_hash <= final_mix(r_hash);
            r_parent   <= NULL_IDX;
        end
        r_cur <= n_cur;
        if (i_cmd.walk) begin
            if (o_sts.walk_done) begin
                r_status <= n_status;
                r_found  <= (hit && r_cmd) ? ram_rdata.value : '0;
            end else begin
                r_parent   <= r_cur;
                r_go_left  <= go_left;
                r_par_node <= ram_rdata;
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_hash   <= r_key_hash;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = VAL_PORT_W'(r_out_found);
    assign o_key_hash    = r_out_hash;
    assign o_key_count   = COUNT_PORT_W'(r_out_count);

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.write_link && i_cmd.write_node))
        else $error("link and node write in the same cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NULL_IDX)
        else $error("entry count beyond store size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> o_sts.out_free)
        else $error("result register loaded while still held");

    a_insert_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_node |-> !full && !r_cmd)
        else $error("node written on full store or on a get");

endmodule

// File: src/hkvs_ctrl.sv
// Controller: sequences hashing, tree walk, insert writes and result hand-off.
module hkvs_ctrl import hkvs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_HASH  = 3'd0;
    localparam logic [2:0] S_MIX   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_LINK  = 3'd3;
    localparam logic [2:0] S_NODE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_HASH);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HASH: begin
                o_cmd.hash_byte = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                o_cmd.mix_start = 1'b1;
                n_state         = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    if (!i_sts.do_insert) begin
                        n_state = S_DONE;
                    end else if (i_sts.par_null) begin
                        n_state = S_NODE;
                    end else begin
                        n_state = S_LINK;
                    end
                end
            end
            S_LINK: begin
                o_cmd.write_link = 1'b1;
                n_state          = S_NODE;
            end
            S_NODE: begin
                o_cmd.write_node = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_HASH;
                end
            end
            default: begin
                n_state = S_HASH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HASH;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/hashed_key_value_store_core.sv
// Top level of the hashed key/value store: stream ports, controller and datapath.
// Sequence: the key bytes are hashed one byte per cycle while bytes arrive, then the final
//   mix, then the tree walk reads one node store entry per level until a hit or a null link,
//   then on insert the node store writes (link into the parent if any, then the new node),
//   then the result register is loaded once it is free. No new key is taken before that;
//   bytes of the next key are taken while a result still waits on the output.
// Reset: synchronous, active low; clears the running hash, the tree root, the entry count
//   and the output valid. The node store is not cleared: the walk only follows links that have been written.
module hashed_key_value_store_core import hkvs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // key byte items
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [7:0] key_byte, [39:8] value
    input  logic                 i_s_axis_tlast,   // key_last
    input  logic [0:0]           i_s_axis_tuser,   // [0] command (0 insert, 1 get)
    // result items
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // [31:0] found_value, [63:32] key_hash,
                                                   // [72:64] key_count, rest zero
    output logic [STATUS_W-1:0]  o_m_axis_tuser    // [2:0] status
);

    t_dp_cmd                 dp_cmd;
    t_dp_sts                 dp_sts;
    logic [VAL_PORT_W-1:0]   found_value;
    logic [HASH_W-1:0]       key_hash;
    logic [COUNT_PORT_W-1:0] key_count;

    // Controller: accepts bytes only while hashing; the walk and the
    // insert writes run with the input held off.
    hkvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Datapath: hash fold, final mix, tree walk over the node store,
    // result register that decouples the output side.
    hkvs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_command     (i_s_axis_tuser[0]),
        .i_key_byte    (i_s_axis_tdata[BYTE_W-1:0]),
        .i_key_last    (i_s_axis_tlast),
        .i_value       (i_s_axis_tdata[BYTE_W+VAL_PORT_W-1:BYTE_W]),
        .i_m_tready    (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_status      (o_m_axis_tuser),
        .o_found_value (found_value),
        .o_key_hash    (key_hash),
        .o_key_count   (key_count)
    );

    // pack result fields, lowest first, zero pad to whole bytes
    assign o_m_axis_tdata = M_TDATA_W'({key_count, key_hash, found_value});

endmodule
